### sv/tsps_pkg.sv
package tsps_pkg;

    localparam int unsigned MAX_STEPS_DEF = 32;
    localparam int unsigned PRESCALE_DEF  = 64;

    localparam int unsigned FREQ_W  = 16;
    localparam int unsigned HOLD_W  = 8;
    localparam int unsigned DUTY_W  = 7;
    localparam int unsigned CLK_W   = 26;
    localparam int unsigned NUM_W   = CLK_W;
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned SEL_W   = 2;
    localparam int unsigned APB_AW  = 4;
    localparam int unsigned APB_DW  = 32;
    localparam int unsigned PROD_W  = FREQ_W + DUTY_W;

    localparam logic [FREQ_W-1:0] BELL_KEY = 16'd2000;
    localparam logic [FREQ_W-1:0] BELL_ALT = 16'd2010;
    localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;
    localparam logic [FREQ_W-1:0] PERIOD_MAX = 16'hffff;

    typedef enum logic [1:0] {
        REG_FREQ_LO     = 2'd0,
        REG_FREQ_HI     = 2'd1,
        REG_CLOCK_HZ    = 2'd2,
        REG_INIT_PERIOD = 2'd3
    } reg_idx_t;

    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_RESTART = 1'b1
    } op_t;

    typedef enum logic [SEL_W-1:0] {
        SEQ_BELL   = 2'd0,
        SEQ_CHARGE = 2'd1,
        SEQ_LOW    = 2'd2
    } seq_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_lo;
        logic [FREQ_W-1:0] freq_hi;
        logic [CLK_W-1:0]  clock_hz;
        logic [FREQ_W-1:0] init_period;
    } cfg_t;

    typedef struct packed {
        logic [HOLD_W-1:0] hold;
        logic [FREQ_W-1:0] freq;
        logic [DUTY_W-1:0] duty;
    } step_t;

    function automatic step_t mk(input logic [HOLD_W-1:0] h, input logic [FREQ_W-1:0] f,
                                 input logic [DUTY_W-1:0] d);
        step_t s;
        s.hold = h;
        s.freq = f;
        s.duty = d;
        return s;
    endfunction

    function automatic step_t bell_step(input logic [IDX_W-1:0] idx);
        step_t s;
        case (idx)
            8'd0:  s = mk(8'd1,   BELL_KEY, 7'd1);
            8'd1:  s = mk(8'd5,   BELL_ALT, 7'd2);
            8'd2:  s = mk(8'd5,   BELL_KEY, 7'd4);
            8'd3:  s = mk(8'd5,   BELL_ALT, 7'd6);
            8'd4:  s = mk(8'd5,   BELL_KEY, 7'd8);
            8'd5:  s = mk(8'd5,   BELL_ALT, 7'd9);
            8'd6:  s = mk(8'd5,   BELL_KEY, 7'd10);
            8'd7:  s = mk(8'd40,  BELL_ALT, 7'd20);
            8'd8:  s = mk(8'd20,  BELL_KEY, 7'd30);
            8'd9:  s = mk(8'd10,  BELL_ALT, 7'd40);
            8'd10: s = mk(8'd5,   BELL_KEY, 7'd50);
            8'd11: s = mk(8'd60,  BELL_ALT, 7'd55);
            8'd12: s = mk(8'd180, BELL_KEY, 7'd50);
            8'd13: s = mk(8'd60,  BELL_ALT, 7'd45);
            8'd14: s = mk(8'd180, BELL_KEY, 7'd40);
            8'd15: s = mk(8'd60,  BELL_ALT, 7'd36);
            8'd16: s = mk(8'd180, BELL_KEY, 7'd32);
            8'd17: s = mk(8'd60,  BELL_ALT, 7'd29);
            8'd18: s = mk(8'd180, BELL_KEY, 7'd26);
            8'd19: s = mk(8'd60,  BELL_ALT, 7'd23);
            8'd20: s = mk(8'd180, BELL_KEY, 7'd21);
            8'd21: s = mk(8'd60,  BELL_ALT, 7'd18);
            8'd22: s = mk(8'd180, BELL_KEY, 7'd16);
            8'd23: s = mk(8'd60,  BELL_ALT, 7'd14);
            8'd24: s = mk(8'd180, BELL_KEY, 7'd13);
            8'd25: s = mk(8'd60,  BELL_ALT, 7'd11);
            8'd26: s = mk(8'd180, BELL_KEY, 7'd10);
            8'd27: s = mk(8'd60,  BELL_ALT, 7'd9);
            8'd28: s = mk(8'd180, BELL_KEY, 7'd8);
            default: s = mk(8'd0, 16'd2500, 7'd1);
        endcase
        return s;
    endfunction

    function automatic step_t charge_step(input logic [IDX_W-1:0] idx);
        step_t s;
        case (idx)
            8'd0:  s = mk(8'd1,   16'd2636, 7'd10);
            8'd1:  s = mk(8'd255, 16'd2636, 7'd40);
            8'd2:  s = mk(8'd255, 16'd2960, 7'd40);
            default: s = mk(8'd0, 16'd1480, 7'd1);
        endcase
        return s;
    endfunction

    function automatic step_t low_step(input logic [IDX_W-1:0] idx);
        step_t s;
        case (idx)
            8'd0, 8'd1: s = mk(8'd160, 16'd1700, 7'd50);
            8'd2, 8'd3: s = mk(8'd160, 16'd1250, 7'd40);
            8'd4:  s = mk(8'd60, 16'd1200, 7'd30);
            8'd5:  s = mk(8'd60, 16'd1150, 7'd20);
            8'd6:  s = mk(8'd60, 16'd1145, 7'd10);
            default: s = mk(8'd0, 16'd1145, 7'd1);
        endcase
        return s;
    endfunction

    // past the end of a table the end entry repeats; unused selector reads the low table
    function automatic step_t rom_step(input logic [SEL_W-1:0] sel, input logic [IDX_W-1:0] idx);
        step_t s;
        case (sel)
            SEQ_BELL:   s = bell_step(idx);
            SEQ_CHARGE: s = charge_step(idx);
            default:    s = low_step(idx);
        endcase
        return s;
    endfunction

endpackage

### sv/tsps_cfg.sv
module tsps_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tsps_pkg::APB_AW-1:0]    paddr,
    input  logic [tsps_pkg::APB_DW-1:0]    pwdata,
    output logic [tsps_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    output tsps_pkg::cfg_t                 cfg
);

    tsps_pkg::cfg_t     cfg_reg;
    tsps_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx    = tsps_pkg::reg_idx_t'(paddr[tsps_pkg::APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.freq_lo     <= 16'd100;
            cfg_reg.freq_hi     <= 16'd20000;
            cfg_reg.clock_hz    <= 26'd20000000;
            cfg_reg.init_period <= 16'd311;
        end else if (wr_en) begin
            unique case (idx)
                tsps_pkg::REG_FREQ_LO:     cfg_reg.freq_lo     <= pwdata[15:0];
                tsps_pkg::REG_FREQ_HI:     cfg_reg.freq_hi     <= pwdata[15:0];
                tsps_pkg::REG_CLOCK_HZ:    cfg_reg.clock_hz    <= pwdata[25:0];
                tsps_pkg::REG_INIT_PERIOD: cfg_reg.init_period <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            tsps_pkg::REG_FREQ_LO:     prdata = 32'(cfg_reg.freq_lo);
            tsps_pkg::REG_FREQ_HI:     prdata = 32'(cfg_reg.freq_hi);
            tsps_pkg::REG_CLOCK_HZ:    prdata = 32'(cfg_reg.clock_hz);
            tsps_pkg::REG_INIT_PERIOD: prdata = 32'(cfg_reg.init_period);
            default:                   prdata = '0;
        endcase
    end

endmodule

### sv/tsps_div.sv
// restoring divider, one quotient bit per cycle
module tsps_div #(
    parameter int unsigned DEN_W = 23
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [tsps_pkg::NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]             den,
    output logic                         done,
    output logic [tsps_pkg::NUM_W-1:0]   quot
);

    localparam int unsigned CNT_W = $clog2(tsps_pkg::NUM_W + 1);

    logic [tsps_pkg::NUM_W-1:0] num_reg;
    logic [DEN_W-1:0]           den_reg;
    logic [DEN_W-1:0]           rem_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [DEN_W:0]             shifted;
    logic [DEN_W:0]             diff;
    logic                       ge;

    assign shifted = {rem_reg, num_reg[tsps_pkg::NUM_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};
    assign done    = done_reg;
    assign quot    = num_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(tsps_pkg::NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in where the dividend bits leave
    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            num_reg <= {num_reg[tsps_pkg::NUM_W-2:0], ge};
        end
    end

endmodule

### sv/tone_sequence_pwm_stepper_unit.sv
// Tone sequence PWM stepper. Each request is a tick sample or a restart and gives exactly one
// result. Restarts, repeated tick values, hold countdowns and the end of a sequence reach the
// output register through the EVAL and FIN states, FIN waiting for the output register to be
// free. A tick that advances to a new step passes LOAD, GO1, WAIT1, TOP, GO2, WAIT2 and FIN:
// the period clock_hz/(PRESCALE*freq) - 1 and then compare period*duty/100 both go through
// one shared restoring divider that yields a single quotient bit per cycle over the 26-bit
// dividend. Only one request is in flight at a time; the next one is accepted in the cycle
// after the result has moved to the output register, even if it has not yet been taken. A
// result still waiting in the output register holds the next one back until it is taken.
module tone_sequence_pwm_stepper_unit #(
    parameter int unsigned MAX_STEPS = tsps_pkg::MAX_STEPS_DEF,
    parameter int unsigned PRESCALE  = tsps_pkg::PRESCALE_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tsps_pkg::APB_AW-1:0] paddr,
    input  logic [tsps_pkg::APB_DW-1:0] pwdata,
    output logic [tsps_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,   // tick_value[15:0], sequence_select[17:16]
    input  logic                        s_tuser,   // opcode
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [39:0]                 m_tdata,   // running[0], period_top[16:1],
                                                   // compare_value[32:17]
    output logic                        m_tuser    // update_valid
);

    localparam int unsigned SIDX_W = $clog2(MAX_STEPS);
    localparam int unsigned PS_W   = $clog2(PRESCALE + 1);
    localparam int unsigned DEN_W  = PS_W + tsps_pkg::FREQ_W;
    localparam logic [SIDX_W-1:0] LAST_IDX = SIDX_W'(MAX_STEPS - 1);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_EVAL  = 9'b000000010,
        ST_LOAD  = 9'b000000100,
        ST_GO1   = 9'b000001000,
        ST_WAIT1 = 9'b000010000,
        ST_TOP   = 9'b000100000,
        ST_GO2   = 9'b001000000,
        ST_WAIT2 = 9'b010000000,
        ST_FIN   = 9'b100000000
    } state_t;

    tsps_pkg::cfg_t cfg;

    state_t                        state_reg, state_next;
    logic [tsps_pkg::TICK_W-1:0]   last_tick_reg, last_tick_next;
    logic [tsps_pkg::HOLD_W-1:0]   hold_reg, hold_next;
    logic [SIDX_W-1:0]             step_reg, step_next;
    logic                          out_valid_reg, out_valid_next;

    // request and working payload
    logic                          op_reg;
    logic [tsps_pkg::TICK_W-1:0]   tick_reg;
    logic [tsps_pkg::SEL_W-1:0]    sel_reg;
    logic [DEN_W-1:0]              den_reg;
    logic [tsps_pkg::DUTY_W-1:0]   duty_reg;
    logic [tsps_pkg::HOLD_W-1:0]   new_hold_reg;
    logic [tsps_pkg::FREQ_W-1:0]   top_reg;
    logic [tsps_pkg::PROD_W-1:0]   prod_reg;
    logic                          res_run_reg;
    logic                          res_upd_reg;
    logic [tsps_pkg::FREQ_W-1:0]   res_per_reg;
    logic [tsps_pkg::FREQ_W-1:0]   res_cmp_reg;
    logic                          o_run_reg;
    logic                          o_upd_reg;
    logic [tsps_pkg::FREQ_W-1:0]   o_per_reg;
    logic [tsps_pkg::FREQ_W-1:0]   o_cmp_reg;

    logic                          s_acc;
    logic                          out_free;
    logic                          is_restart;
    tsps_pkg::step_t               step_rd;
    logic [tsps_pkg::FREQ_W-1:0]   f_clamp;
    logic [tsps_pkg::FREQ_W-1:0]   f_eff;
    logic [DEN_W-1:0]              den_calc;
    logic [tsps_pkg::DUTY_W-1:0]   duty_cap;
    logic [tsps_pkg::NUM_W-1:0]    q_m1;
    logic [tsps_pkg::FREQ_W-1:0]   top_calc;
    logic                          div_start;
    logic [tsps_pkg::NUM_W-1:0]    div_num;
    logic [DEN_W-1:0]              div_den;
    logic                          div_done;
    logic [tsps_pkg::NUM_W-1:0]    div_quot;

    tsps_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tsps_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_acc      = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;
    assign is_restart = (op_reg == tsps_pkg::OP_RESTART);

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = o_upd_reg;
    assign m_tdata  = {7'd0, o_cmp_reg, o_per_reg, o_run_reg};

    assign step_rd = tsps_pkg::rom_step(sel_reg, tsps_pkg::IDX_W'(step_reg));

    always_comb begin
        if (step_rd.freq < cfg.freq_lo) begin
            f_clamp = cfg.freq_lo;
        end else if (step_rd.freq > cfg.freq_hi) begin
            f_clamp = cfg.freq_hi;
        end else begin
            f_clamp = step_rd.freq;
        end
        f_eff    = (f_clamp == '0) ? tsps_pkg::FREQ_W'(1) : f_clamp;
        den_calc = DEN_W'(f_eff) * DEN_W'(PRESCALE);
        duty_cap = (step_rd.duty > tsps_pkg::DUTY_FULL) ? tsps_pkg::DUTY_FULL : step_rd.duty;
    end

    always_comb begin
        q_m1 = div_quot - 1'b1;
        if (div_quot == '0 || q_m1 == '0 || q_m1[tsps_pkg::NUM_W-1:tsps_pkg::FREQ_W] != '0) begin
            top_calc = tsps_pkg::PERIOD_MAX;
        end else begin
            top_calc = q_m1[tsps_pkg::FREQ_W-1:0];
        end
    end

    assign div_start = (state_reg == ST_GO1) || (state_reg == ST_GO2);
    assign div_num   = (state_reg == ST_GO1) ? cfg.clock_hz : tsps_pkg::NUM_W'(prod_reg);
    assign div_den   = (state_reg == ST_GO1) ? den_reg : DEN_W'(tsps_pkg::DUTY_FULL);

    always_comb begin
        state_next     = state_reg;
        last_tick_next = last_tick_reg;
        hold_next      = hold_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = ST_FIN;
                if (is_restart) begin
                    step_next = '0;
                    hold_next = tsps_pkg::HOLD_W'(1);
                end else if (tick_reg != last_tick_reg) begin
                    last_tick_next = tick_reg;
                    if (hold_reg != '0) begin
                        hold_next = hold_reg - 1'b1;
                    end else if (step_rd.hold != '0) begin
                        if (step_reg < LAST_IDX) begin
                            step_next = step_reg + 1'b1;
                        end
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:  state_next = ST_GO1;
            ST_GO1:   state_next = ST_WAIT1;
            ST_WAIT1: begin
                if (div_done) begin
                    state_next = ST_TOP;
                end
            end
            ST_TOP:   state_next = ST_GO2;
            ST_GO2:   state_next = ST_WAIT2;
            ST_WAIT2: begin
                if (div_done) begin
                    hold_next  = new_hold_reg;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            last_tick_reg <= '0;
            hold_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            last_tick_reg <= last_tick_next;
            hold_reg      <= hold_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            op_reg   <= s_tuser;
            tick_reg <= s_tdata[15:0];
            sel_reg  <= s_tdata[17:16];
        end
        if (state_reg == ST_EVAL) begin
            // a repeated tick and the end of a sequence give an all-zero result
            res_run_reg <= is_restart || (tick_reg != last_tick_reg && hold_reg != '0);
            res_upd_reg <= is_restart;
            res_per_reg <= is_restart ? cfg.init_period : '0;
            res_cmp_reg <= '0;
        end
        if (state_reg == ST_LOAD) begin
            den_reg      <= den_calc;
            duty_reg     <= duty_cap;
            new_hold_reg <= step_rd.hold;
        end
        if (state_reg == ST_TOP) begin
            top_reg  <= top_calc;
            prod_reg <= tsps_pkg::PROD_W'(top_calc) * tsps_pkg::PROD_W'(duty_reg);
        end
        if (state_reg == ST_WAIT2 && div_done) begin
            res_run_reg <= 1'b1;
            res_upd_reg <= 1'b1;
            res_per_reg <= top_reg;
            res_cmp_reg <= div_quot[tsps_pkg::FREQ_W-1:0];
        end
        if (state_reg == ST_FIN && out_free) begin
            o_run_reg <= res_run_reg;
            o_upd_reg <= res_upd_reg;
            o_per_reg <= res_per_reg;
            o_cmp_reg <= res_cmp_reg;
        end
    end

endmodule

### verif/tone_sequence_pwm_stepper_unit_tb.sv
module tone_sequence_pwm_stepper_unit_tb;

    localparam int CLK_HALF         = 10;
    localparam int RESET_CYCLES     = 8;
    // a step advance goes through the shared divider twice
    localparam int SETTLE_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int RANDOM_PER_PHASE = 85;
    localparam int NUM_PHASES       = 7;
    localparam logic [1:0] SEQ_SPARE = 2'd3;

    typedef struct packed {
        logic        running;
        logic        upd;
        logic [15:0] period;
        logic [15:0] compare;
    } tone_res_t;

    typedef struct packed {
        logic [7:0]  hold;
        logic [15:0] freq;
        logic [6:0]  duty;
    } tone_t;

    typedef struct {
        tsps_pkg::op_t op;
        logic [15:0]   tick;
        logic [1:0]    sel;
        bit            typed;
        tone_res_t     res;
    } request_t;

    localparam tone_res_t RES_IDLE  = '0;
    localparam tone_res_t RES_COUNT = {1'b1, 1'b0, 16'd0, 16'd0};

    logic                        aclk;
    logic                        aresetn;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [tsps_pkg::APB_AW-1:0] paddr;
    logic [tsps_pkg::APB_DW-1:0] pwdata;
    logic [tsps_pkg::APB_DW-1:0] prdata;
    logic                        pready;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [23:0]                 s_tdata;
    logic                        s_tuser;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [39:0]                 m_tdata;
    logic                        m_tuser;

    // register shadows and stepper state
    logic [15:0] cfg_min;
    logic [15:0] cfg_max;
    logic [25:0] cfg_clk;
    logic [15:0] cfg_init;
    logic [15:0] seen_tick;
    logic [7:0]  hold_left;
    int unsigned step_idx;

    tone_res_t   tone_q[$];
    request_t    rows[$];
    tone_res_t   want;
    tone_res_t   got;

    int          errors;
    int          checked;
    int          sent;
    int          settings;
    int          updates_seen;
    int          ends_seen;
    int          send_idle;
    int          recv_idle;
    int          stall_len;
    int          idle_cycles;
    logic [15:0] gen_tick;
    logic [1:0]  run_sel;
    logic [1:0]  alt_sel;

    tone_sequence_pwm_stepper_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    function automatic tone_t rom_tone(logic [1:0] sel, int unsigned idx);
        tone_t       t;
        int unsigned d;
        t = '0;
        d = 1;
        if (sel == tsps_pkg::SEQ_BELL) begin
            if (idx > 28) begin
                t = {8'd0, 16'd2500, 7'd1};
            end else begin
                t.freq = idx[0] ? tsps_pkg::BELL_ALT : tsps_pkg::BELL_KEY;
                case (idx)
                    0: t.hold = 8'd1;
                    7: t.hold = 8'd40;
                    8: t.hold = 8'd20;
                    9: t.hold = 8'd10;
                    1, 2, 3, 4, 5, 6, 10: t.hold = 8'd5;
                    default: t.hold = idx[0] ? 8'd60 : 8'd180;
                endcase
                case (idx)
                    0: d = 1;    1: d = 2;    2: d = 4;    3: d = 6;    4: d = 8;
                    5: d = 9;    6: d = 10;   7: d = 20;   8: d = 30;   9: d = 40;
                    10: d = 50;  11: d = 55;  12: d = 50;  13: d = 45;  14: d = 40;
                    15: d = 36;  16: d = 32;  17: d = 29;  18: d = 26;  19: d = 23;
                    20: d = 21;  21: d = 18;  22: d = 16;  23: d = 14;  24: d = 13;
                    25: d = 11;  26: d = 10;  27: d = 9;   default: d = 8;
                endcase
                t.duty = d[6:0];
            end
        end else if (sel == tsps_pkg::SEQ_CHARGE) begin
            case (idx)
                0: t = {8'd1, 16'd2636, 7'd10};
                1: t = {8'd255, 16'd2636, 7'd40};
                2: t = {8'd255, 16'd2960, 7'd40};
                default: t = {8'd0, 16'd1480, 7'd1};
            endcase
        end else begin
            // low voltage table, also read by the spare selector
            case (idx)
                0, 1: t = {8'd160, 16'd1700, 7'd50};
                2, 3: t = {8'd160, 16'd1250, 7'd40};
                4: t = {8'd60, 16'd1200, 7'd30};
                5: t = {8'd60, 16'd1150, 7'd20};
                6: t = {8'd60, 16'd1145, 7'd10};
                default: t = {8'd0, 16'd1145, 7'd1};
            endcase
        end
        return t;
    endfunction

    function automatic tone_res_t predict_tone(tsps_pkg::op_t op, logic [15:0] tick,
                                               logic [1:0] sel);
        tone_res_t   r;
        tone_t       s;
        int unsigned f;
        int unsigned q;
        int unsigned top;
        r = RES_IDLE;
        if (op == tsps_pkg::OP_RESTART) begin
            step_idx  = 0;
            hold_left = 8'd1;
            r = {1'b1, 1'b1, cfg_init, 16'd0};
        end else if (tick != seen_tick) begin
            seen_tick = tick;
            s = rom_tone(sel, step_idx);
            if (hold_left != 0) begin
                hold_left = hold_left - 8'd1;
                r = RES_COUNT;
            end else if (s.hold != 0) begin
                if (step_idx < tsps_pkg::MAX_STEPS_DEF - 1)
                    step_idx++;
                s = rom_tone(sel, step_idx);
                f = s.freq;
                if (f < cfg_min)
                    f = cfg_min;
                else if (f > cfg_max)
                    f = cfg_max;
                if (f == 0)
                    f = 1;
                q = cfg_clk / tsps_pkg::PRESCALE_DEF / f;
                top = (q == 0 || q - 1 == 0 || q - 1 > 65535) ? 65535 : q - 1;
                r.running = 1'b1;
                r.upd     = 1'b1;
                r.period  = top[15:0];
                r.compare = (s.duty >= 100) ? top[15:0] : 16'((top * s.duty) / 100);
                hold_left = s.hold;
                updates_seen++;
            end else begin
                ends_seen++;
            end
        end
        return r;
    endfunction

    task automatic add_row(tsps_pkg::op_t op, logic [15:0] tick, logic [1:0] sel, bit typed,
                           tone_res_t res);
        request_t rq;
        rq.op    = op;
        rq.tick  = tick;
        rq.sel   = sel;
        rq.typed = typed;
        rq.res   = res;
        rows.push_back(rq);
    endtask

    task automatic write_reg(tsps_pkg::reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (idx)
            tsps_pkg::REG_FREQ_LO:     cfg_min  = value[15:0];
            tsps_pkg::REG_FREQ_HI:     cfg_max  = value[15:0];
            tsps_pkg::REG_CLOCK_HZ:    cfg_clk  = value[25:0];
            tsps_pkg::REG_INIT_PERIOD: cfg_init = value[15:0];
        endcase
    endtask

    task automatic set_config(int unsigned fmin, int unsigned fmax, int unsigned clk_hz,
                              int unsigned init);
        write_reg(tsps_pkg::REG_FREQ_LO, fmin);
        write_reg(tsps_pkg::REG_FREQ_HI, fmax);
        write_reg(tsps_pkg::REG_CLOCK_HZ, clk_hz);
        write_reg(tsps_pkg::REG_INIT_PERIOD, init);
        settings++;
    endtask

    task automatic send_request(request_t rq);
        int        gap;
        tone_res_t predicted;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, rq.sel, rq.tick};
        s_tuser  <= rq.op;
        do @(posedge aclk); while (!s_tready);
        predicted = predict_tone(rq.op, rq.tick, rq.sel);
        tone_q.push_back(rq.typed ? rq.res : predicted);
        sent++;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (tone_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // mostly restart-then-counting runs, with a second selector mixed in so that
    // short bell holds push the index far enough for the other tables to end it
    task automatic random_phase(int n);
        request_t rq;
        int       done;
        int       r;
        done = 0;
        while (done < n) begin
            rq.typed = 1'b0;
            rq.res   = RES_IDLE;
            rq.op    = tsps_pkg::OP_TICK;
            rq.sel   = ($urandom_range(0, 99) < 25) ? alt_sel : run_sel;
            if ($urandom_range(0, 99) < 5)
                rq.sel = 2'($urandom_range(0, 3));
            r = $urandom_range(0, 99);
            if (r < 2) begin
                rq.op   = tsps_pkg::OP_RESTART;
                rq.tick = 16'($urandom);
                rq.sel  = 2'($urandom_range(0, 3));
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: run_sel = tsps_pkg::SEQ_BELL;
                    6:       run_sel = tsps_pkg::SEQ_CHARGE;
                    7, 8:    run_sel = tsps_pkg::SEQ_LOW;
                    default: run_sel = SEQ_SPARE;
                endcase
                alt_sel = 2'($urandom_range(0, 3));
                done++;
            end else if (r < 7) begin
                // repeated tick value, which the block answers with an all-zero result
                rq.tick = gen_tick;
            end else begin
                gen_tick = (r < 15) ? 16'($urandom) : gen_tick + 16'd1;
                rq.tick  = gen_tick;
                done++;
            end
            send_request(rq);
        end
    endtask

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_len > 0) begin
                m_tready <= 1'b0;
                repeat (stall_len) @(posedge aclk);
                stall_len = 0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[0], m_tuser, m_tdata[16:1], m_tdata[32:17]};
            if (tone_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result running %0d update %0d period %0d compare %0d",
                         $time, got.running, got.upd, got.period, got.compare);
            end else begin
                want = tone_q.pop_front();
                check_field("running", want.running, got.running);
                check_field("update_valid", want.upd, got.upd);
                check_field("period_top", want.period, got.period);
                check_field("compare_value", want.compare, got.compare);
                checked++;
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, tone_q.size());
        $display("tone_sequence_pwm_stepper_unit: mismatch");
        $finish;
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= tsps_pkg::OP_TICK;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        cfg_min   = 16'd100;
        cfg_max   = 16'd20000;
        cfg_clk   = 26'd20000000;
        cfg_init  = 16'd311;
        seen_tick = 16'd0;
        hold_left = 8'd0;
        step_idx  = 0;
        errors = 0;
        checked = 0;
        sent = 0;
        settings = 1;
        updates_seen = 0;
        ends_seen = 0;
        stall_len = 0;
        send_idle = 37;
        recv_idle = 53;
        run_sel = tsps_pkg::SEQ_BELL;
        alt_sel = tsps_pkg::SEQ_CHARGE;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset values, repeated tick, countdown, bell advances,
        // end of sequence through the charging table, restart
        add_row(tsps_pkg::OP_TICK, 16'h0000, tsps_pkg::SEQ_BELL, 1'b1, RES_IDLE);
        add_row(tsps_pkg::OP_RESTART, 16'hffff, SEQ_SPARE, 1'b1,
                {1'b1, 1'b1, 16'd311, 16'd0});
        add_row(tsps_pkg::OP_TICK, 16'h0000, tsps_pkg::SEQ_LOW, 1'b1, RES_IDLE);
        add_row(tsps_pkg::OP_TICK, 16'hffff, tsps_pkg::SEQ_LOW, 1'b1, RES_COUNT);
        add_row(tsps_pkg::OP_TICK, 16'd1, tsps_pkg::SEQ_BELL, 1'b0, RES_IDLE);
        for (int t = 2; t <= 6; t++)
            add_row(tsps_pkg::OP_TICK, 16'(t), tsps_pkg::SEQ_CHARGE, 1'b1, RES_COUNT);
        add_row(tsps_pkg::OP_TICK, 16'd7, tsps_pkg::SEQ_BELL, 1'b0, RES_IDLE);
        for (int t = 8; t <= 12; t++)
            add_row(tsps_pkg::OP_TICK, 16'(t), SEQ_SPARE, 1'b1, RES_COUNT);
        add_row(tsps_pkg::OP_TICK, 16'd13, tsps_pkg::SEQ_BELL, 1'b0, RES_IDLE);
        for (int t = 14; t <= 18; t++)
            add_row(tsps_pkg::OP_TICK, 16'(t), tsps_pkg::SEQ_BELL, 1'b1, RES_COUNT);
        add_row(tsps_pkg::OP_TICK, 16'd19, tsps_pkg::SEQ_CHARGE, 1'b1, RES_IDLE);
        add_row(tsps_pkg::OP_TICK, 16'd20, tsps_pkg::SEQ_BELL, 1'b0, RES_IDLE);
        add_row(tsps_pkg::OP_RESTART, 16'h0000, tsps_pkg::SEQ_CHARGE, 1'b1,
                {1'b1, 1'b1, 16'd311, 16'd0});
        foreach (rows[i])
            send_request(rows[i]);
        gen_tick = 16'd20;
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: set_config(1, 65535, 67108863, 65535);
                1: set_config(65535, 65535, 64, 0);
                2: set_config(3000, 1000, 20000000, 311);
                3: set_config(1, 1, 67108863, 12345);
                4: set_config($urandom_range(1, 65535), $urandom_range(1, 65535),
                              $urandom_range(64, 67108863), $urandom_range(0, 65535));
                5: set_config(1, 1, 127, 311);
                default: set_config(100, 20000, 20000000, 311);
            endcase
            send_idle = (ph < 2) ? 37 : (ph < 4) ? 53 : 0;
            recv_idle = (ph < 2) ? 53 : (ph < 4) ? 37 : 0;
            if (ph == 1 || ph == 4)
                stall_len = HOLD_OFF_CYCLES;
            random_phase(RANDOM_PER_PHASE);
            drain();
        end

        $display("%0d requests sent across %0d register settings, %0d results checked",
                 sent, settings, checked);
        $display("%0d tone updates and %0d sequence ends among them", updates_seen, ends_seen);
        if (errors == 0)
            $display("tone_sequence_pwm_stepper_unit: match");
        else
            $display("tone_sequence_pwm_stepper_unit: mismatch");
        $finish;
    end

endmodule

### files.f
sv/tsps_pkg.sv
sv/tsps_cfg.sv
sv/tsps_div.sv
sv/tone_sequence_pwm_stepper_unit.sv
verif/tone_sequence_pwm_stepper_unit_tb.sv
